/* rtl/gb3_pkg.sv */
`timescale 1ns / 1ps
package gb3_pkg;

	// frame limits and register reset values
	localparam int unsigned GB3_MAX_WIDTH    = 2048;
	localparam int unsigned GB3_MAX_HEIGHT   = 4096;
	localparam int unsigned GB3_WIDTH_RESET  = 640;
	localparam int unsigned GB3_HEIGHT_RESET = 480;

	// configuration port
	localparam int unsigned GB3_WIDTH_BITS  = 12;
	localparam int unsigned GB3_HEIGHT_BITS = 13;
	localparam int unsigned GB3_CFG_W       = 13;
	localparam int unsigned GB3_IDX_W       = 2;
	localparam logic [GB3_IDX_W-1:0] GB3_REG_WIDTH  = 2'd0;
	localparam logic [GB3_IDX_W-1:0] GB3_REG_HEIGHT = 2'd1;

	// input commands
	localparam logic GB3_CMD_PUSH  = 1'b0;
	localparam logic GB3_CMD_DRAIN = 1'b1;

	// pixel layout
	localparam int unsigned GB3_PIX_W    = 8;
	localparam int unsigned GB3_CH       = 3;
	localparam int unsigned GB3_PIX_BITS = GB3_PIX_W * GB3_CH;

	// 3x3 kernel
	localparam int unsigned GB3_K      = 3;
	localparam int unsigned GB3_TAPS   = GB3_K * GB3_K;
	localparam int unsigned GB3_CENTRE = GB3_TAPS / 2;
	localparam int unsigned GB3_WEIGHT [GB3_TAPS] = '{1, 2, 1, 2, 4, 2, 1, 2, 1};
	localparam int unsigned GB3_SHIFT  = 4;
	localparam int unsigned GB3_SUM_W  = GB3_PIX_W + GB3_SHIFT;

	// output queue
	localparam int unsigned GB3_OQ_DEPTH = 4;
	localparam int unsigned GB3_OQ_PTR_W = $clog2(GB3_OQ_DEPTH);
	localparam int unsigned GB3_OQ_CNT_W = $clog2(GB3_OQ_DEPTH + 1);

	// which neighbours lie inside the image
	typedef struct packed {
		logic up;
		logic down;
		logic left;
		logic right;
	} gb3_nbr_t;

	// per item control carried down the pipeline
	typedef struct packed {
		logic     produce;
		gb3_nbr_t nbr;
		logic     last;
	} gb3_ctl_t;

	// one finished output pixel
	typedef struct packed {
		logic [GB3_PIX_W-1:0] red;
		logic [GB3_PIX_W-1:0] green;
		logic [GB3_PIX_W-1:0] blue;
		logic                 last;
	} gb3_result_t;

	// zero means one, anything above the limit is the limit
	function automatic int unsigned gb3_eff_dim(input int unsigned value,
		input int unsigned maxv);
		if (value == 0) begin
			return 1;
		end
		if (value > maxv) begin
			return maxv;
		end
		return value;
	endfunction

endpackage

/* rtl/gb3_if.sv */
`timescale 1ns / 1ps
// pixel input channel
interface gb3_pix_in_if
	import gb3_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic                 command;
	logic [GB3_PIX_W-1:0] red_in;
	logic [GB3_PIX_W-1:0] green_in;
	logic [GB3_PIX_W-1:0] blue_in;

	modport source (output valid, output command, output red_in, output green_in,
		output blue_in, input ready);
	modport sink (input valid, input command, input red_in, input green_in,
		input blue_in, output ready);
endinterface

// blurred pixel output channel
interface gb3_pix_out_if
	import gb3_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [GB3_PIX_W-1:0] red_out;
	logic [GB3_PIX_W-1:0] green_out;
	logic [GB3_PIX_W-1:0] blue_out;
	logic                 frame_last;

	modport source (output valid, output red_out, output green_out, output blue_out,
		output frame_last, input ready);
	modport sink (input valid, input red_out, input green_out, input blue_out,
		input frame_last, output ready);
endinterface

/* rtl/gb3_ram.sv */
`timescale 1ns / 1ps
module gb3_ram #(
	parameter int unsigned WIDTH = 24,
	parameter int unsigned DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port, read returns old data
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/gb3_lane.sv */
`timescale 1ns / 1ps
module gb3_lane
	import gb3_pkg::*;
(
	input  logic [GB3_TAPS-1:0][GB3_PIX_W-1:0] taps,
	input  gb3_nbr_t                           nbr,
	output logic [GB3_PIX_W-1:0]               pix
);

	logic [GB3_K-1:0]     row_ok;
	logic [GB3_K-1:0]     col_ok;
	logic [GB3_TAPS-1:0]  tap_ok;
	logic [GB3_PIX_W-1:0] tap_val;
	logic [GB3_SUM_W-1:0] acc;

	// outside neighbours fall back to the centre pixel
	assign row_ok = {nbr.down, 1'b1, nbr.up};
	assign col_ok = {nbr.right, 1'b1, nbr.left};

	for (genvar g = 0; g < GB3_TAPS; g++) begin : g_ok
		assign tap_ok[g] = row_ok[g / GB3_K] & col_ok[g % GB3_K];
	end

	// nine tap weighted sum
	always_comb begin
		acc     = '0;
		tap_val = '0;
		for (int i = 0; i < GB3_TAPS; i++) begin
			tap_val = tap_ok[i] ? taps[i] : taps[GB3_CENTRE];
			acc = acc + GB3_SUM_W'(tap_val) * GB3_SUM_W'(GB3_WEIGHT[i]);
		end
	end

	// divide by sixteen, rounding down
	assign pix = acc[GB3_SHIFT +: GB3_PIX_W];

endmodule

/* rtl/gb3_outq.sv */
`timescale 1ns / 1ps
module gb3_outq
	import gb3_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  gb3_result_t             push_data,
	output logic [GB3_OQ_CNT_W-1:0] count,
	gb3_pix_out_if.source           out_ch
);

	gb3_result_t             mem_q [GB3_OQ_DEPTH];
	logic [GB3_OQ_PTR_W-1:0] head_q;
	logic [GB3_OQ_PTR_W-1:0] tail_q;
	logic [GB3_OQ_CNT_W-1:0] count_q;
	logic                    pop;

	// output side
	assign pop               = out_ch.valid && out_ch.ready;
	assign out_ch.valid      = count_q != '0;
	assign out_ch.red_out    = mem_q[head_q].red;
	assign out_ch.green_out  = mem_q[head_q].green;
	assign out_ch.blue_out   = mem_q[head_q].blue;
	assign out_ch.frame_last = mem_q[head_q].last;
	assign count             = count_q;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[tail_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				tail_q <= tail_q + GB3_OQ_PTR_W'(1);
			end
			if (pop) begin
				head_q <= head_q + GB3_OQ_PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + GB3_OQ_CNT_W'(1);
				2'b01:   count_q <= count_q - GB3_OQ_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/gaussian_blur_3x3_stream.sv */
`timescale 1ns / 1ps
// path: stage 1, window and stage 2, then the output queue hold each result in turn;
// output (r, c) follows input (r+1, c+1); drains finish the last row
// throughput: 1 item per cycle while the output queue has room for results in flight
// reset: counters and controls cleared, queue empty, size registers 640 x 480 (clamped)
// line stores, window and payload are not cleared; stale data only feeds masked taps
module gaussian_blur_3x3_stream
	import gb3_pkg::*;
#(
	parameter int unsigned MAX_WIDTH  = GB3_MAX_WIDTH,
	parameter int unsigned MAX_HEIGHT = GB3_MAX_HEIGHT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [GB3_IDX_W-1:0] cfg_index,
	input  logic [GB3_CFG_W-1:0] cfg_data,
	gb3_pix_in_if.sink           in_ch,
	gb3_pix_out_if.source        out_ch
);

	localparam int unsigned CW  = $clog2(MAX_WIDTH);
	localparam int unsigned WDW = CW + 1;
	localparam int unsigned HDW = $clog2(MAX_HEIGHT) + 1;
	localparam int unsigned RW  = HDW + 1;
	localparam int unsigned OCW = GB3_OQ_CNT_W + 1;

	// frame size and position counters
	logic [WDW-1:0] w_eff_q;
	logic [HDW-1:0] h_eff_q;
	logic [CW-1:0]  in_col_q;
	logic [RW-1:0]  in_row_q;
	logic [CW-1:0]  out_col_q;
	logic [HDW-1:0] out_row_q;

	logic           cfg_hit;
	logic           is_drain;
	logic           drain_phase;
	logic           take;
	logic [WDW-1:0] col_inc;
	logic           col_wrap;
	logic [WDW-1:0] ocol_inc;
	logic [HDW-1:0] orow_inc;
	logic           ocol_last;
	logic           orow_last;
	gb3_ctl_t       ctl_now;

	// pipeline
	logic                    take_s1;
	gb3_ctl_t                ctl_s1;
	logic [GB3_PIX_BITS-1:0] px_s1;
	logic [CW-1:0]           col_s1;
	logic                    hit_s1;
	logic [GB3_PIX_BITS-1:0] fwd_top_s1;
	logic [GB3_PIX_BITS-1:0] fwd_mid_s1;
	logic [GB3_PIX_BITS-1:0] up_rdata;
	logic [GB3_PIX_BITS-1:0] mid_rdata;
	logic [GB3_PIX_BITS-1:0] top_s1;
	logic [GB3_PIX_BITS-1:0] mid_s1;
	gb3_ctl_t                ctl_s2;

	logic [GB3_K-1:0][GB3_K-1:0][GB3_PIX_BITS-1:0] win_q;
	logic [GB3_CH-1:0][GB3_PIX_W-1:0]              lane_pix;
	gb3_result_t                                   result;
	logic [GB3_OQ_CNT_W-1:0]                       oq_count;
	logic [OCW-1:0]                                occupancy;

	// width or height register writes restart the frame
	assign cfg_hit = cfg_we && (cfg_index == GB3_REG_WIDTH || cfg_index == GB3_REG_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_eff_q <= WDW'(gb3_eff_dim(GB3_WIDTH_RESET, MAX_WIDTH));
			h_eff_q <= HDW'(gb3_eff_dim(GB3_HEIGHT_RESET, MAX_HEIGHT));
		end else if (cfg_we) begin
			if (cfg_index == GB3_REG_WIDTH) begin
				w_eff_q <= WDW'(gb3_eff_dim(32'(cfg_data[GB3_WIDTH_BITS-1:0]), MAX_WIDTH));
			end
			if (cfg_index == GB3_REG_HEIGHT) begin
				h_eff_q <= HDW'(gb3_eff_dim(32'(cfg_data[GB3_HEIGHT_BITS-1:0]), MAX_HEIGHT));
			end
		end
	end

	// input side: pushes before frame end, drains after, others dropped
	assign is_drain    = in_ch.command == GB3_CMD_DRAIN;
	assign drain_phase = in_row_q >= RW'(h_eff_q);
	assign take        = in_ch.valid && in_ch.ready && (is_drain == drain_phase);

	assign col_inc  = WDW'(in_col_q) + WDW'(1);
	assign col_wrap = col_inc >= w_eff_q;

	// output position and neighbour flags
	assign ocol_inc  = WDW'(out_col_q) + WDW'(1);
	assign orow_inc  = out_row_q + HDW'(1);
	assign ocol_last = ocol_inc >= w_eff_q;
	assign orow_last = orow_inc >= h_eff_q;

	always_comb begin
		ctl_now.produce   = (in_row_q >= RW'(2)) || (in_row_q == RW'(1) && in_col_q != '0);
		ctl_now.nbr.up    = out_row_q != '0;
		ctl_now.nbr.down  = !orow_last;
		ctl_now.nbr.left  = out_col_q != '0;
		ctl_now.nbr.right = !ocol_last;
		ctl_now.last      = orow_last && ocol_last;
	end

	// position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg_hit) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (take) begin
			if (ctl_now.produce && ctl_now.last) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				if (col_wrap) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + RW'(1);
				end else begin
					in_col_q <= col_inc[CW-1:0];
				end
				if (ctl_now.produce) begin
					if (ocol_last) begin
						out_col_q <= '0;
						out_row_q <= orow_inc;
					end else begin
						out_col_q <= ocol_inc[CW-1:0];
					end
				end
			end
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			take_s1 <= 1'b0;
			ctl_s1  <= '0;
			hit_s1  <= 1'b0;
		end else begin
			take_s1 <= take;
			ctl_s1  <= take ? ctl_now : '0;
			hit_s1  <= take && take_s1 && (in_col_q == col_s1);
		end
	end

	// stage 1 payload; forward the write that lands in the read cycle
	always_ff @(posedge clk) begin
		px_s1      <= (in_ch.command == GB3_CMD_PUSH) ?
			{in_ch.red_in, in_ch.green_in, in_ch.blue_in} : '0;
		col_s1     <= in_col_q;
		fwd_top_s1 <= mid_s1;
		fwd_mid_s1 <= px_s1;
	end

	assign top_s1 = hit_s1 ? fwd_top_s1 : up_rdata;
	assign mid_s1 = hit_s1 ? fwd_mid_s1 : mid_rdata;

	// line stores: read at transfer, written back rotated in the following cycle
	gb3_ram #(
		.WIDTH (GB3_PIX_BITS),
		.DEPTH (MAX_WIDTH)
	) u_upper (
		.clk   (clk),
		.we    (take_s1),
		.waddr (col_s1),
		.wdata (mid_s1),
		.re    (take),
		.raddr (in_col_q),
		.rdata (up_rdata)
	);

	gb3_ram #(
		.WIDTH (GB3_PIX_BITS),
		.DEPTH (MAX_WIDTH)
	) u_middle (
		.clk   (clk),
		.we    (take_s1),
		.waddr (col_s1),
		.wdata (px_s1),
		.re    (take),
		.raddr (in_col_q),
		.rdata (mid_rdata)
	);

	// 3x3 window shift
	always_ff @(posedge clk) begin
		if (take_s1) begin
			for (int r = 0; r < GB3_K; r++) begin
				for (int c = 0; c < GB3_K - 1; c++) begin
					win_q[r][c] <= win_q[r][c+1];
				end
			end
			win_q[0][GB3_K-1] <= top_s1;
			win_q[1][GB3_K-1] <= mid_s1;
			win_q[2][GB3_K-1] <= px_s1;
		end
	end

	// stage 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= take_s1 ? ctl_s1 : '0;
		end
	end

	// one lane per color channel
	for (genvar ch = 0; ch < GB3_CH; ch++) begin : g_lane
		logic [GB3_TAPS-1:0][GB3_PIX_W-1:0] taps;

		for (genvar t = 0; t < GB3_TAPS; t++) begin : g_tap
			assign taps[t] = win_q[t / GB3_K][t % GB3_K][(GB3_CH-1-ch)*GB3_PIX_W +: GB3_PIX_W];
		end

		gb3_lane u_lane (
			.taps (taps),
			.nbr  (ctl_s2.nbr),
			.pix  (lane_pix[ch])
		);
	end

	// merge lanes into one result
	always_comb begin
		result.red   = lane_pix[0];
		result.green = lane_pix[1];
		result.blue  = lane_pix[2];
		result.last  = ctl_s2.last;
	end

	gb3_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (ctl_s2.produce),
		.push_data (result),
		.count     (oq_count),
		.out_ch    (out_ch)
	);

	// accept only while the queue has room for every result in flight
	assign occupancy = OCW'(oq_count) + OCW'(ctl_s1.produce) + OCW'(ctl_s2.produce);
	assign in_ch.ready = occupancy < OCW'(GB3_OQ_DEPTH);

`ifndef SYNTH
	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		occupancy <= OCW'(GB3_OQ_DEPTH))
		else $error("output queue overcommitted");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		WDW'(in_col_q) < w_eff_q)
		else $error("input column beyond frame width");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		take && ctl_now.produce && ctl_now.last |=>
		in_row_q == '0 && in_col_q == '0 && out_row_q == '0 && out_col_q == '0)
		else $error("counters not cleared after last output");
`endif

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
module tb;
	import gb3_pkg::*;

	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned HOLD_CYCLES   = 300;
	localparam int unsigned QUIET_LIMIT   = 5000;
	localparam int unsigned EXTREME_CUT   = 200;
	localparam int unsigned RANDOM_ITEMS  = 1200;
	localparam int unsigned MAX_REPORTS   = 200;
	localparam logic [GB3_IDX_W-1:0] REG_SPARE = GB3_IDX_W'(3);
	localparam gb3_result_t NO_RESULT = '0;

	typedef enum int unsigned {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	// one row of the directed table: a register write or a transfer
	typedef struct packed {
		logic                    is_cfg;
		logic [GB3_IDX_W-1:0]    idx;
		logic [GB3_CFG_W-1:0]    data;
		logic                    cmd;
		logic [GB3_PIX_BITS-1:0] px;
		logic                    known;
		gb3_result_t             want;
	} blur_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [GB3_IDX_W-1:0] cfg_index;
	logic [GB3_CFG_W-1:0] cfg_data;

	gb3_pix_in_if  pix_in ();
	gb3_pix_out_if pix_out ();

	gaussian_blur_3x3_stream uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_ch    (pix_in),
		.out_ch   (pix_out)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// blur predictor state
	logic [GB3_WIDTH_BITS-1:0]  blur_width;
	logic [GB3_HEIGHT_BITS-1:0] blur_height;
	logic [GB3_PIX_BITS-1:0]    blur_upper [GB3_MAX_WIDTH];
	logic [GB3_PIX_BITS-1:0]    blur_middle [GB3_MAX_WIDTH];
	logic [GB3_PIX_BITS-1:0]    blur_win [3][3];
	int unsigned                in_row, in_col, out_row, out_col;

	gb3_result_t pending_pixels [$];
	gb3_result_t oldest;

	int unsigned error_count;
	int unsigned taken_items;
	int unsigned ignored_items;
	int unsigned checked_pixels;
	int unsigned frames_done;
	int unsigned quiet_cycles;
	int unsigned sender_idle_pct;
	int unsigned stall_pct;
	int unsigned holds_asked;
	int unsigned holds_taken;
	int unsigned hold_left;

	// zero means one pixel, anything past the limit is clamped
	function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned maxv);
		if (v == 0) begin
			return 1;
		end
		return (v > maxv) ? maxv : v;
	endfunction

	function automatic void blur_restart();
		in_row  = 0;
		in_col  = 0;
		out_row = 0;
		out_col = 0;
	endfunction

	function automatic void blur_reset();
		blur_width  = GB3_WIDTH_BITS'(GB3_WIDTH_RESET);
		blur_height = GB3_HEIGHT_BITS'(GB3_HEIGHT_RESET);
		for (int i = 0; i < GB3_MAX_WIDTH; i++) begin
			blur_upper[i]  = '0;
			blur_middle[i] = '0;
		end
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				blur_win[r][c] = '0;
			end
		end
		blur_restart();
	endfunction

	function automatic void blur_config(input logic [GB3_IDX_W-1:0] idx,
		input logic [GB3_CFG_W-1:0] data);
		if (idx == GB3_REG_WIDTH) begin
			blur_width = data[GB3_WIDTH_BITS-1:0];
			blur_restart();
		end else if (idx == GB3_REG_HEIGHT) begin
			blur_height = data[GB3_HEIGHT_BITS-1:0];
			blur_restart();
		end
	endfunction

	// weighted 3x3 sum of one channel; taps outside the image take the centre
	function automatic logic [GB3_PIX_W-1:0] blur_channel(input int unsigned sh,
		input bit [2:0] row_ok, input bit [2:0] col_ok);
		int unsigned acc;
		logic [GB3_PIX_W-1:0] centre, tap;
		int r, c;
		acc    = 0;
		centre = GB3_PIX_W'(blur_win[1][1] >> sh);
		for (r = 0; r < 3; r++) begin
			for (c = 0; c < 3; c++) begin
				tap = (row_ok[r] && col_ok[c]) ? GB3_PIX_W'(blur_win[r][c] >> sh) : centre;
				acc += ((r == 1) ? 2 : 1) * ((c == 1) ? 2 : 1) * tap;
			end
		end
		return GB3_PIX_W'(acc >> GB3_SHIFT);
	endfunction

	// advance the predictor by one accepted item; returns 1 when it yields a pixel
	function automatic bit blur_step(input logic cmd, input logic [GB3_PIX_BITS-1:0] px_in,
		output bit ignored, output gb3_result_t blurred);
		int unsigned w, h, col;
		logic [GB3_PIX_BITS-1:0] px, top, mid;
		bit make, last_px;
		bit [2:0] row_ok, col_ok;
		int r;
		w       = clamp_dim(blur_width, GB3_MAX_WIDTH);
		h       = clamp_dim(blur_height, GB3_MAX_HEIGHT);
		blurred = '0;
		ignored = 1'b0;
		// drains only count once the frame is fully pushed, pushes only before
		if ((cmd == GB3_CMD_DRAIN) != (in_row >= h)) begin
			ignored = 1'b1;
			return 1'b0;
		end
		px  = (cmd == GB3_CMD_DRAIN) ? '0 : px_in;
		col = in_col % GB3_MAX_WIDTH;
		top = blur_upper[col];
		mid = blur_middle[col];
		blur_upper[col]  = mid;
		blur_middle[col] = px;
		for (r = 0; r < 3; r++) begin
			blur_win[r][0] = blur_win[r][1];
			blur_win[r][1] = blur_win[r][2];
		end
		blur_win[0][2] = top;
		blur_win[1][2] = mid;
		blur_win[2][2] = px;
		make = (in_row >= 2) || (in_row == 1 && in_col >= 1);
		in_col++;
		if (in_col >= w) begin
			in_col = 0;
			in_row++;
		end
		if (!make) begin
			return 1'b0;
		end
		row_ok[0] = (out_row != 0);
		row_ok[1] = 1'b1;
		row_ok[2] = (out_row + 1 < h);
		col_ok[0] = (out_col != 0);
		col_ok[1] = 1'b1;
		col_ok[2] = (out_col + 1 < w);
		blurred.red   = blur_channel(16, row_ok, col_ok);
		blurred.green = blur_channel(8, row_ok, col_ok);
		blurred.blue  = blur_channel(0, row_ok, col_ok);
		last_px = (out_row + 1 >= h) && (out_col + 1 >= w);
		blurred.last = last_px;
		if (last_px) begin
			blur_restart();
		end else begin
			out_col++;
			if (out_col >= w) begin
				out_col = 0;
				out_row++;
			end
		end
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
		input int unsigned want);
		error_count++;
		if (error_count <= MAX_REPORTS) begin
			$display("mismatch at %0t ns: %s got %0h expected %0h", $time, what, got, want);
		end
	endtask

	function automatic logic [GB3_PIX_BITS-1:0] random_pixel();
		logic [GB3_PIX_BITS-1:0] px;
		px = GB3_PIX_BITS'($urandom);
		// push some channels to the rails
		for (int i = 0; i < GB3_CH; i++) begin
			if ($urandom_range(4) == 0) begin
				px[i*GB3_PIX_W +: GB3_PIX_W] = $urandom_range(1) ? 8'hff : 8'h00;
			end
		end
		return px;
	endfunction

	task automatic set_idling(input idle_mode_t mode);
		sender_idle_pct = (mode == IDLE_SENDER) ? 67 : (mode == IDLE_BOTH) ? 11 : 0;
		stall_pct       = (mode == IDLE_RECEIVER) ? 67 : (mode == IDLE_BOTH) ? 11 : 0;
	endtask

	// one input transfer, with random idle cycles ahead of it
	task automatic send_item(input logic cmd, input logic [GB3_PIX_BITS-1:0] px,
		input bit known, input gb3_result_t want);
		gb3_result_t blurred;
		bit ignored, made;
		while ($urandom_range(99) < sender_idle_pct) begin
			@(negedge clk);
			pix_in.valid <= 1'b0;
			@(posedge clk);
		end
		@(negedge clk);
		pix_in.valid    <= 1'b1;
		pix_in.command  <= cmd;
		pix_in.red_in   <= px[23:16];
		pix_in.green_in <= px[15:8];
		pix_in.blue_in  <= px[7:0];
		do @(posedge clk); while (!pix_in.ready);
		made = blur_step(cmd, px, ignored, blurred);
		if (ignored) begin
			ignored_items++;
		end else begin
			taken_items++;
		end
		if (made) begin
			pending_pixels.push_back(known ? want : blurred);
		end
	endtask

	// stop sending and let every outstanding pixel come out
	task automatic wait_drained();
		@(negedge clk);
		pix_in.valid <= 1'b0;
		while (pending_pixels.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [GB3_IDX_W-1:0] idx, input logic [GB3_CFG_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		blur_config(idx, data);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// configure a frame size and stream it: pushes, then drains
	task automatic run_frame(input logic [GB3_CFG_W-1:0] wdata, input logic [GB3_CFG_W-1:0] hdata,
		input int unsigned cut, input bit pause_mid, input bit hold, input bit noisy);
		int unsigned w, h, pixels, total, k;
		logic cmd;
		wait_drained();
		if ($urandom_range(1)) begin
			write_reg(GB3_REG_WIDTH, wdata);
			write_reg(GB3_REG_HEIGHT, hdata);
		end else begin
			write_reg(GB3_REG_HEIGHT, hdata);
			write_reg(GB3_REG_WIDTH, wdata);
		end
		if (noisy && $urandom_range(9) == 0) begin
			write_reg(REG_SPARE, GB3_CFG_W'($urandom));
		end
		w      = clamp_dim(wdata[GB3_WIDTH_BITS-1:0], GB3_MAX_WIDTH);
		h      = clamp_dim(hdata[GB3_HEIGHT_BITS-1:0], GB3_MAX_HEIGHT);
		pixels = w * h;
		total  = pixels + w + 1;
		if (cut == 0 || cut > total) begin
			cut = total;
		end
		for (k = 0; k < cut; k++) begin
			if (hold && k == 0) begin
				holds_asked++;
			end
			if (pause_mid && k == total / 2) begin
				wait_drained();
			end
			cmd = (k < pixels) ? GB3_CMD_PUSH : GB3_CMD_DRAIN;
			// out-of-phase item that the block should drop
			if (noisy && $urandom_range(24) == 0) begin
				send_item(~cmd, random_pixel(), 1'b0, NO_RESULT);
			end
			send_item(cmd, random_pixel(), 1'b0, NO_RESULT);
		end
	endtask

	// directed table: uniform frames have a known result, the rest is predicted
	blur_row_t directed_rows [30] = '{
		'{1'b1, GB3_REG_WIDTH,  13'd2, GB3_CMD_PUSH,  24'h000000, 1'b0, NO_RESULT},
		'{1'b1, GB3_REG_HEIGHT, 13'd2, GB3_CMD_PUSH,  24'h000000, 1'b0, NO_RESULT},
		// drain before the frame is complete is dropped
		'{1'b0, GB3_REG_WIDTH,  13'd0, GB3_CMD_DRAIN, 24'h5a5a5a, 1'b0, NO_RESULT},
		'{1'b0, GB3_REG_WIDTH,  13'd0, GB3_CMD_PUSH,  24'hffffff, 1'b0, NO_RESULT},
		'{1'b0, GB3_REG_WIDTH,  13'd0, GB3_CMD_PUSH,  24'hffffff, 1'b0, NO_RESULT},
		'{1'b0, GB3_REG_WIDTH,  13'd0, GB3_CMD_PUSH,  24'hffffff, 1'b0, NO_RESULT},
		'{1'b0, GB3_REG_WIDTH,  13'd0, GB3_CMD_PUSH,  24'hffffff, 1'b1,
			'{8'hff, 8'hff, 8'hff, 1'b0}},
		// push while draining is dropped
		'{1'b0, GB3_REG_WIDTH,  13'd0, GB3_CMD_PUSH,  24'h123456, 1'b0, NO_RESULT},
		'{1'b0, GB3_REG_WIDTH,  13'd0, GB3_CMD_DRAIN, 24'ha5a5a5, 1'b1,
			'{8'hff, 8'hff, 8'hff, 1'b0}},
		'{1'b0, GB3_REG_WIDTH,  13'd0, GB3_CMD_DRAIN, 24'h000000, 1'b1,
			'{8'hff, 8'hff, 8'hff, 1'b0}},
		'{1'b0, GB3_REG_WIDTH,  13'd0, GB3_CMD_DRAIN, 24'hffffff, 1'b1,
			'{8'hff, 8'hff, 8'hff, 1'b1}},
		'{1'b0, GB3_REG_WIDTH,  13'd0, GB3_CMD_PUSH,  24'h000000, 1'b0, NO_RESULT},
		'{1'b0, GB3_REG_WIDTH,  13'd0, GB3_CMD_PUSH,  24'h000000, 1'b0, NO_RESULT},
		'{1'b0, GB3_REG_WIDTH,  13'd0, GB3_CMD_PUSH,  24'h000000, 1'b0, NO_RESULT},
		'{1'b0, GB3_REG_WIDTH,  13'd0, GB3_CMD_PUSH,  24'h000000, 1'b1,
			'{8'h00, 8'h00, 8'h00, 1'b0}},
		'{1'b0, GB3_REG_WIDTH,  13'd0, GB3_CMD_DRAIN, 24'hffffff, 1'b1,
			'{8'h00, 8'h00, 8'h00, 1'b0}},
		'{1'b0, GB3_REG_WIDTH,  13'd0, GB3_CMD_DRAIN, 24'hffffff, 1'b1,
			'{8'h00, 8'h00, 8'h00, 1'b0}},
		'{1'b0, GB3_REG_WIDTH,  13'd0, GB3_CMD_DRAIN, 24'hffffff, 1'b1,
			'{8'h00, 8'h00, 8'h00, 1'b1}},
		'{1'b0, GB3_REG_WIDTH,  13'd0, GB3_CMD_PUSH,  24'h0180fe, 1'b0, NO_RESULT},
		'{1'b0, GB3_REG_WIDTH,  13'd0, GB3_CMD_PUSH,  24'hff007f, 1'b0, NO_RESULT},
		'{1'b0, GB3_REG_WIDTH,  13'd0, GB3_CMD_PUSH,  24'h800100, 1'b0, NO_RESULT},
		'{1'b0, GB3_REG_WIDTH,  13'd0, GB3_CMD_PUSH,  24'h7efeff, 1'b0, NO_RESULT},
		'{1'b0, GB3_REG_WIDTH,  13'd0, GB3_CMD_DRAIN, 24'h000000, 1'b0, NO_RESULT},
		'{1'b0, GB3_REG_WIDTH,  13'd0, GB3_CMD_DRAIN, 24'h000000, 1'b0, NO_RESULT},
		'{1'b0, GB3_REG_WIDTH,  13'd0, GB3_CMD_DRAIN, 24'h000000, 1'b0, NO_RESULT},
		// zero sizes mean a single pixel frame, which is returned unchanged
		'{1'b1, GB3_REG_WIDTH,  13'd0, GB3_CMD_PUSH,  24'h000000, 1'b0, NO_RESULT},
		'{1'b1, GB3_REG_HEIGHT, 13'd0, GB3_CMD_PUSH,  24'h000000, 1'b0, NO_RESULT},
		'{1'b0, GB3_REG_WIDTH,  13'd0, GB3_CMD_PUSH,  24'habcdef, 1'b0, NO_RESULT},
		'{1'b0, GB3_REG_WIDTH,  13'd0, GB3_CMD_DRAIN, 24'h000000, 1'b0, NO_RESULT},
		'{1'b0, GB3_REG_WIDTH,  13'd0, GB3_CMD_DRAIN, 24'h000000, 1'b1,
			'{8'hab, 8'hcd, 8'hef, 1'b1}}
	};

	// output side: ready pattern plus the long hold-off on request
	initial begin
		pix_out.ready = 1'b0;
		holds_taken   = 0;
		hold_left     = 0;
		forever begin
			@(negedge clk);
			if (holds_taken != holds_asked) begin
				holds_taken = holds_asked;
				hold_left   = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				pix_out.ready <= 1'b0;
			end else begin
				pix_out.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// check every output transfer against the oldest expected pixel
	always @(posedge clk) begin
		if (arst_n && pix_out.valid && pix_out.ready) begin
			if (pending_pixels.size() == 0) begin
				report_mismatch("pixel with none expected, red", pix_out.red_out, 0);
			end else begin
				oldest = pending_pixels.pop_front();
				checked_pixels++;
				if (pix_out.red_out !== oldest.red) begin
					report_mismatch("red_out", pix_out.red_out, oldest.red);
				end
				if (pix_out.green_out !== oldest.green) begin
					report_mismatch("green_out", pix_out.green_out, oldest.green);
				end
				if (pix_out.blue_out !== oldest.blue) begin
					report_mismatch("blue_out", pix_out.blue_out, oldest.blue);
				end
				if (pix_out.frame_last !== oldest.last) begin
					report_mismatch("frame_last", pix_out.frame_last, oldest.last);
				end
				if (oldest.last) begin
					frames_done++;
				end
			end
		end
	end

	// watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
			$display("Some tests failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int unsigned first_item, frame_no, cut;
		logic [GB3_CFG_W-1:0] wdata, hdata;
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = '0;
		cfg_data         = '0;
		pix_in.valid     = 1'b0;
		pix_in.command   = GB3_CMD_PUSH;
		pix_in.red_in    = '0;
		pix_in.green_in  = '0;
		pix_in.blue_in   = '0;
		error_count      = 0;
		taken_items      = 0;
		ignored_items    = 0;
		checked_pixels   = 0;
		frames_done      = 0;
		quiet_cycles     = 0;
		holds_asked      = 0;
		set_idling(IDLE_NONE);
		blur_reset();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg) begin
				wait_drained();
				write_reg(directed_rows[i].idx, directed_rows[i].data);
			end else begin
				send_item(directed_rows[i].cmd, directed_rows[i].px, directed_rows[i].known,
					directed_rows[i].want);
			end
		end

		// size extremes, each cut short: widest single row, tallest column, full size
		set_idling(IDLE_BOTH);
		run_frame(13'h1fff, 13'd1, EXTREME_CUT, 1'b0, 1'b0, 1'b0);
		run_frame(13'd1, 13'h1fff, EXTREME_CUT, 1'b0, 1'b0, 1'b0);
		run_frame(GB3_CFG_W'(GB3_MAX_WIDTH), GB3_CFG_W'(GB3_MAX_HEIGHT), EXTREME_CUT,
			1'b0, 1'b0, 1'b0);

		// random frames, mostly small, some broken off, some with stray items
		first_item = taken_items;
		frame_no   = 0;
		while (taken_items - first_item < RANDOM_ITEMS) begin
			set_idling(idle_mode_t'((frame_no / 2) % 4));
			case ($urandom_range(9))
				0: wdata = '0;
				1: wdata = GB3_CFG_W'($urandom_range(13, 64));
				2: wdata = GB3_CFG_W'(13'h1000 | $urandom_range(1, 12));
				default: wdata = GB3_CFG_W'($urandom_range(1, 12));
			endcase
			case ($urandom_range(9))
				0: hdata = '0;
				1: hdata = GB3_CFG_W'($urandom_range(9, 24));
				default: hdata = GB3_CFG_W'($urandom_range(1, 8));
			endcase
			cut = ($urandom_range(5) == 0) ? $urandom_range(1, 30) : 0;
			if (frame_no == 2 || frame_no == 25) begin
				// large enough to fill the block while the output is held off
				run_frame(13'd16, 13'd8, 0, 1'b0, 1'b1, 1'b1);
			end else begin
				run_frame(wdata, hdata, cut, (frame_no % 7 == 3), 1'b0, 1'b1);
			end
			frame_no++;
		end

		wait_drained();
		if (pending_pixels.size() != 0) begin
			report_mismatch("pixels never delivered", 0, pending_pixels.size());
		end
		$display("covered %0d directed rows, size extremes and %0d random frames",
			$size(directed_rows), frame_no);
		$display("%0d items taken, %0d dropped by design, %0d pixels checked, %0d frames closed",
			taken_items, ignored_items, checked_pixels, frames_done);
		if (error_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/gb3_pkg.sv
rtl/gb3_if.sv
rtl/gb3_ram.sv
rtl/gb3_lane.sv
rtl/gb3_outq.sv
rtl/gaussian_blur_3x3_stream.sv
sim/tb.sv
